// ===== rtl/core/pcg_pkg.sv =====
`default_nettype none

package pcg_pkg;

  // LCG constants
  localparam logic [63:0] LCG_MULT   = 64'd6364136223846793005;
  localparam logic [63:0] LCG_STREAM = 64'hda3e39cb94b95bdb;
  localparam logic [63:0] LCG_INC    = {LCG_STREAM[62:0], 1'b1};
  // State after seeding with zero: clear, draw, add zero, draw
  localparam logic [63:0] LCG_RESET_STATE = LCG_MULT * LCG_INC + LCG_INC;

  // Request opcodes
  localparam logic [1:0] OP_RAW     = 2'd0;
  localparam logic [1:0] OP_FRAC    = 2'd1;
  localparam logic [1:0] OP_BOUNDED = 2'd2;
  localparam logic [1:0] OP_RESEED  = 2'd3;

  // Multiply phases of one draw
  localparam logic [1:0] MUL_IDLE = 2'd0;
  localparam logic [1:0] MUL_P0   = 2'd1;
  localparam logic [1:0] MUL_P1   = 2'd2;
  localparam logic [1:0] MUL_P2   = 2'd3;

  // Divider operand select
  localparam logic DIV_THR  = 1'b0;
  localparam logic DIV_WORD = 1'b1;

  // Result select
  localparam logic [2:0] RSEL_ZERO     = 3'd0;
  localparam logic [2:0] RSEL_RAW      = 3'd1;
  localparam logic [2:0] RSEL_FRAC     = 3'd2;
  localparam logic [2:0] RSEL_LOW      = 3'd3;
  localparam logic [2:0] RSEL_LOW_WORD = 3'd4;
  localparam logic [2:0] RSEL_LOW_REM  = 3'd5;
  localparam logic [2:0] RSEL_ERR      = 3'd6;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } request_t;

  typedef struct packed {
    logic [52:0]        random_bits;
    logic signed [31:0] random_integer;
    logic               range_error;
  } result_t;

  typedef struct packed {
    logic       req_load;
    logic [1:0] mul_phase;
    logic       reseed;
    logic       frac_save;
    logic       thr_load;
    logic       div_start;
    logic       div_sel;
    logic       res_load;
    logic [2:0] res_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       range_err;
    logic       span_one;
    logic       span_full;
    logic       word_ok;
    logic       div_busy;
  } status_t;

  // XSH-RR output permutation of the old state
  function automatic logic [31:0] xsh_rr(input logic [63:0] old);
    logic [63:0] mixed;
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [4:0]  rot_l;
    mixed = (old >> 18) ^ old;
    xs    = mixed[58:27];
    rot   = old[63:59];
    rot_l = 5'd0 - rot;
    return (xs >> rot) | (xs << rot_l);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pcg_divider.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle; only the remainder is kept
module pcg_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [31:0]      remainder
);

  logic [31:0] quo;
  logic [4:0]  count;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {remainder, quo[31]};
  assign diff  = trial - {1'b0, divisor};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 5'd31;
    end else if (busy) begin
      count <= count - 5'd1;
      if (count == 5'd0) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quo       <= dividend;
    end else if (busy) begin
      quo <= {quo[30:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        remainder <= diff[31:0];
      end else begin
        remainder <= trial[31:0];
      end
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (remainder < divisor))
    else $error("remainder not below divisor");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("divider did not start");

endmodule

`default_nettype wire

// ===== rtl/core/pcg_datapath.sv =====
`default_nettype none

module pcg_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pcg_pkg::request_t req,
  input  wire logic              cfg_write,
  input  wire logic [63:0]       cfg_seed,
  input  wire pcg_pkg::cmd_t     cmd,
  output pcg_pkg::status_t       status,
  output pcg_pkg::result_t       rsp
);

  pcg_pkg::request_t req_q;
  logic [63:0] seed;
  logic [63:0] lcg_state;
  logic [63:0] acc;
  logic [31:0] word;
  logic [26:0] frac_hi;
  logic [31:0] thr;

  logic [32:0] diff;
  logic [31:0] bound;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [31:0] div_dividend;
  logic        div_busy;
  logic [31:0] div_rem;
  logic [31:0] offset;
  logic [31:0] low_sum;
  pcg_pkg::result_t rsp_next;

  // Request capture and seed register
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_write) begin
      seed <= cfg_seed;
    end
  end

  // Span decode
  assign diff  = {req_q.range_high[31], req_q.range_high}
               - {req_q.range_low[31], req_q.range_low};
  assign bound = diff[31:0] + 32'd1;

  assign status.opcode    = req_q.opcode;
  assign status.range_err = req_q.range_low > req_q.range_high;
  assign status.span_one  = req_q.range_low == req_q.range_high;
  assign status.span_full = diff == 33'h0_FFFF_FFFF;
  assign status.word_ok   = word >= thr;
  assign status.div_busy  = div_busy;

  // Shared 32x32 multiplier for the 64-bit state product
  always_comb begin
    case (cmd.mul_phase)
      pcg_pkg::MUL_P1: begin
        mul_a = lcg_state[63:32];
        mul_b = pcg_pkg::LCG_MULT[31:0];
      end
      pcg_pkg::MUL_P2: begin
        mul_a = lcg_state[31:0];
        mul_b = pcg_pkg::LCG_MULT[63:32];
      end
      default: begin
        mul_a = lcg_state[31:0];
        mul_b = pcg_pkg::LCG_MULT[31:0];
      end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // LCG state and draw word
  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state <= pcg_pkg::LCG_RESET_STATE;
    end else if (cmd.reseed) begin
      lcg_state <= pcg_pkg::LCG_INC + seed;
    end else if (cmd.mul_phase == pcg_pkg::MUL_P2) begin
      lcg_state <= acc + {mul_p[31:0], 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.mul_phase)
      pcg_pkg::MUL_P0: begin
        acc  <= mul_p + pcg_pkg::LCG_INC;
        word <= pcg_pkg::xsh_rr(lcg_state);
      end
      pcg_pkg::MUL_P1: begin
        acc <= acc + {mul_p[31:0], 32'd0};
      end
      default: begin
      end
    endcase
  end

  // Fraction high part and rejection threshold
  always_ff @(posedge clk) begin
    if (cmd.frac_save) begin
      frac_hi <= word[31:5];
    end
    if (cmd.thr_load) begin
      thr <= div_rem;
    end
  end

  // Remainder unit
  assign div_dividend = (cmd.div_sel == pcg_pkg::DIV_WORD) ? word : (32'd0 - bound);

  pcg_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (bound),
    .busy      (div_busy),
    .remainder (div_rem)
  );

  // Result assembly
  assign offset  = (cmd.res_sel == pcg_pkg::RSEL_LOW_REM) ? div_rem : word;
  assign low_sum = req_q.range_low + offset;

  always_comb begin
    rsp_next = '0;
    case (cmd.res_sel)
      pcg_pkg::RSEL_RAW:      rsp_next.random_bits    = {21'd0, word};
      pcg_pkg::RSEL_FRAC:     rsp_next.random_bits    = {frac_hi, word[31:6]};
      pcg_pkg::RSEL_LOW:      rsp_next.random_integer = req_q.range_low;
      pcg_pkg::RSEL_LOW_WORD: rsp_next.random_integer = low_sum;
      pcg_pkg::RSEL_LOW_REM:  rsp_next.random_integer = low_sum;
      pcg_pkg::RSEL_ERR:      rsp_next.range_error    = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pcg_control.sv =====
`default_nettype none

module pcg_control (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  input  wire pcg_pkg::status_t status,
  output pcg_pkg::cmd_t         cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_MUL0      = 4'd2;
  localparam logic [3:0] S_MUL1      = 4'd3;
  localparam logic [3:0] S_MUL2      = 4'd4;
  localparam logic [3:0] S_POST      = 4'd5;
  localparam logic [3:0] S_THR_START = 4'd6;
  localparam logic [3:0] S_THR_WAIT  = 4'd7;
  localparam logic [3:0] S_REM_START = 4'd8;
  localparam logic [3:0] S_REM_WAIT  = 4'd9;
  localparam logic [3:0] S_RESULT    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       second;
  logic       second_next;
  logic [2:0] sel;
  logic [2:0] sel_next;
  logic       slot_free;

  assign req_stall = state != S_IDLE;
  assign slot_free = !rsp_valid || !rsp_stall;

  // Sequencer
  always_comb begin
    state_next  = state;
    second_next = second;
    sel_next    = sel;
    cmd         = '0;
    cmd.res_sel = sel;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.req_load = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        second_next = 1'b0;
        case (status.opcode)
          pcg_pkg::OP_RAW, pcg_pkg::OP_FRAC: state_next = S_MUL0;
          pcg_pkg::OP_BOUNDED: begin
            if (status.range_err) begin
              sel_next   = pcg_pkg::RSEL_ERR;
              state_next = S_RESULT;
            end else if (status.span_one) begin
              sel_next   = pcg_pkg::RSEL_LOW;
              state_next = S_RESULT;
            end else if (status.span_full) begin
              state_next = S_MUL0;
            end else begin
              state_next = S_THR_START;
            end
          end
          default: begin
            cmd.reseed = 1'b1;
            state_next = S_MUL0;
          end
        endcase
      end
      S_MUL0: begin
        cmd.mul_phase = pcg_pkg::MUL_P0;
        state_next    = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_phase = pcg_pkg::MUL_P1;
        state_next    = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_phase = pcg_pkg::MUL_P2;
        state_next    = S_POST;
      end
      S_POST: begin
        case (status.opcode)
          pcg_pkg::OP_RAW: begin
            sel_next   = pcg_pkg::RSEL_RAW;
            state_next = S_RESULT;
          end
          pcg_pkg::OP_FRAC: begin
            if (!second) begin
              cmd.frac_save = 1'b1;
              second_next   = 1'b1;
              state_next    = S_MUL0;
            end else begin
              sel_next   = pcg_pkg::RSEL_FRAC;
              state_next = S_RESULT;
            end
          end
          pcg_pkg::OP_BOUNDED: begin
            if (status.span_full) begin
              sel_next   = pcg_pkg::RSEL_LOW_WORD;
              state_next = S_RESULT;
            end else if (status.word_ok) begin
              state_next = S_REM_START;
            end else begin
              // rejected draw, try again
              state_next = S_MUL0;
            end
          end
          default: begin
            sel_next   = pcg_pkg::RSEL_ZERO;
            state_next = S_RESULT;
          end
        endcase
      end
      S_THR_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = pcg_pkg::DIV_THR;
        state_next    = S_THR_WAIT;
      end
      S_THR_WAIT: begin
        if (!status.div_busy) begin
          cmd.thr_load = 1'b1;
          state_next   = S_MUL0;
        end
      end
      S_REM_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = pcg_pkg::DIV_WORD;
        state_next    = S_REM_WAIT;
      end
      S_REM_WAIT: begin
        if (!status.div_busy) begin
          sel_next   = pcg_pkg::RSEL_LOW_REM;
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (slot_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
      sel    <= pcg_pkg::RSEL_ZERO;
    end else begin
      state  <= state_next;
      second <= second_next;
      sel    <= sel_next;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("divider restarted while busy");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!rsp_valid || !rsp_stall))
    else $error("result overwritten before taken");

  a_mul_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul_phase == pcg_pkg::MUL_P2) |-> ($past(cmd.mul_phase) == pcg_pkg::MUL_P1))
    else $error("multiply phases out of order");

endmodule

`default_nettype wire

// ===== rtl/core/pcg32_random_generator.sv =====
`default_nettype none
// A raw word, a reseed or a full span takes one draw and a fraction two; an inverted or
// single-value range needs no draw; other bounded spans draw until a word is accepted,
// between two 32-step remainder passes (threshold first, then the final remainder).
// One request at a time; draws use the shared 32x32 multiplier in phases MUL0 to MUL2.
// Next request is taken in the cycle after the result is loaded, even if it is not yet taken.
// Reset: state set to the zero-seed value, seed register cleared, no result pending.

module pcg32_random_generator (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire pcg_pkg::request_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output pcg_pkg::result_t       rsp,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [63:0]       cfg_seed
);

  pcg_pkg::cmd_t    cmd;
  pcg_pkg::status_t status;

  assign cfg_ready = 1'b1;

  pcg_control u_control (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pcg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_seed  (cfg_seed),
    .cmd       (cmd),
    .status    (status),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== verif/pcg32_random_generator_tb.sv =====
`timescale 1ns / 1ps

module pcg32_random_generator_tb;

  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  localparam int unsigned RANDOM_PER_PHASE = 200;
  localparam int unsigned RANDOM_PHASES    = 6;
  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned DRAIN_CYCLES     = 200;

  // generator constants, 64-bit LCG with fixed odd increment
  localparam logic [63:0] MULTIPLIER = 64'd6364136223846793005;
  localparam logic [63:0] STREAM     = 64'hda3e39cb94b95bdb;
  localparam logic [63:0] INCREMENT  = {STREAM[62:0], 1'b1};

  localparam logic signed [31:0] MIN_INT = 32'sh8000_0000;
  localparam logic signed [31:0] MAX_INT = 32'sh7fff_ffff;

  localparam pcg_pkg::result_t ZERO_RESULT = '0;
  localparam pcg_pkg::result_t RANGE_ERR   = '{53'd0, 32'sd0, 1'b1};

  typedef struct packed {
    pcg_pkg::request_t stim;
    logic              typed;
    pcg_pkg::result_t  answer;
  } vector_t;

  // directed requests; typed answers only where obvious
  localparam int unsigned NUM_DIRECTED = 20;
  localparam vector_t DIRECTED [NUM_DIRECTED] = '{
    '{'{pcg_pkg::OP_RAW,     32'sd0,  32'sd0},    1'b0, ZERO_RESULT},
    '{'{pcg_pkg::OP_FRAC,    32'sd0,  32'sd0},    1'b0, ZERO_RESULT},
    '{'{pcg_pkg::OP_BOUNDED, MIN_INT, MAX_INT},   1'b0, ZERO_RESULT},
    '{'{pcg_pkg::OP_BOUNDED, MIN_INT, MIN_INT},   1'b1, '{53'd0, MIN_INT, 1'b0}},
    '{'{pcg_pkg::OP_BOUNDED, MAX_INT, MAX_INT},   1'b1, '{53'd0, MAX_INT, 1'b0}},
    '{'{pcg_pkg::OP_BOUNDED, 32'sd0,  32'sd0},    1'b1, ZERO_RESULT},
    '{'{pcg_pkg::OP_BOUNDED, MAX_INT, MIN_INT},   1'b1, RANGE_ERR},
    '{'{pcg_pkg::OP_BOUNDED, 32'sd1,  32'sd0},    1'b1, RANGE_ERR},
    '{'{pcg_pkg::OP_BOUNDED, -32'sd1, -32'sd2},   1'b1, RANGE_ERR},
    '{'{pcg_pkg::OP_BOUNDED, 32'sd0,  32'sd1},    1'b0, ZERO_RESULT},
    '{'{pcg_pkg::OP_BOUNDED, 32'sd0,  32'sd2},    1'b0, ZERO_RESULT},
    '{'{pcg_pkg::OP_BOUNDED, MIN_INT, 32'sd0},    1'b0, ZERO_RESULT},
    '{'{pcg_pkg::OP_BOUNDED, 32'sd0,  MAX_INT},   1'b0, ZERO_RESULT},
    '{'{pcg_pkg::OP_BOUNDED, MIN_INT, MAX_INT - 32'sd1}, 1'b0, ZERO_RESULT},
    '{'{pcg_pkg::OP_BOUNDED, -32'sd1, 32'sd1},    1'b0, ZERO_RESULT},
    '{'{pcg_pkg::OP_RESEED,  32'sd0,  32'sd0},    1'b1, ZERO_RESULT},
    '{'{pcg_pkg::OP_RAW,     32'sd0,  32'sd0},    1'b0, ZERO_RESULT},
    '{'{pcg_pkg::OP_FRAC,    MAX_INT, MIN_INT},   1'b0, ZERO_RESULT},
    '{'{pcg_pkg::OP_RESEED,  MAX_INT, MIN_INT},   1'b1, ZERO_RESULT},
    '{'{pcg_pkg::OP_RAW,     MIN_INT, MAX_INT},   1'b0, ZERO_RESULT}
  };

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  pcg_pkg::request_t req;
  logic              rsp_valid;
  logic              rsp_stall;
  pcg_pkg::result_t  rsp;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [63:0]       cfg_seed;

  pcg32_random_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_seed  (cfg_seed)
  );

  // generator copy: state and seed register
  logic [63:0] gen_state;
  logic [63:0] gen_seed;

  pcg_pkg::result_t pending_results [$];
  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned seeds_written;
  int unsigned op_count [4];
  int unsigned cycle_count;
  bit          quiet;
  bit          hold_request;

  // one XSH-RR draw, advances the LCG
  function automatic logic [31:0] pcg_next_word();
    logic [63:0] prev;
    logic [63:0] mix;
    logic [31:0] xs;
    logic [63:0] rotated;
    prev      = gen_state;
    gen_state = prev * MULTIPLIER + INCREMENT;
    mix       = (prev >> 18) ^ prev;
    xs        = mix[58:27];
    rotated   = {xs, xs} >> prev[63:59];
    return rotated[31:0];
  endfunction

  // two-step seeding: clear, draw, add seed, draw
  function automatic void pcg_reseed(logic [63:0] s);
    logic [31:0] unused;
    gen_state = '0;
    unused    = pcg_next_word();
    gen_state = gen_state + s;
    unused    = pcg_next_word();
  endfunction

  function automatic pcg_pkg::result_t compute_result(pcg_pkg::request_t r);
    pcg_pkg::result_t res;
    longint      lo;
    longint      hi;
    longint      span;
    logic [31:0] bound;
    logic [31:0] thr;
    logic [31:0] word;
    logic [31:0] offset;
    logic [31:0] w1;
    logic [31:0] w2;
    res = '0;
    case (r.opcode)
      pcg_pkg::OP_RAW: begin
        res.random_bits = 53'(pcg_next_word());
      end
      pcg_pkg::OP_FRAC: begin
        w1 = pcg_next_word();
        w2 = pcg_next_word();
        res.random_bits = {w1[31:5], w2[31:6]};
      end
      pcg_pkg::OP_BOUNDED: begin
        lo = longint'(r.range_low);
        hi = longint'(r.range_high);
        if (lo > hi) begin
          res.range_error = 1'b1;
        end else begin
          span = hi - lo + 1;
          if (span == 1) begin
            offset = '0;
          end else if (span == 64'sh1_0000_0000) begin
            offset = pcg_next_word();
          end else begin
            // modulo rejection below 2^32 mod span
            bound = span[31:0];
            thr   = (32'd0 - bound) % bound;
            word  = pcg_next_word();
            while (word < thr) word = pcg_next_word();
            offset = word % bound;
          end
          res.random_integer = r.range_low + offset;
        end
      end
      pcg_pkg::OP_RESEED: begin
        pcg_reseed(gen_seed);
      end
    endcase
    return res;
  endfunction

  // bounded ranges weighted toward small spans, with edge shapes mixed in
  function automatic pcg_pkg::request_t random_request();
    pcg_pkg::request_t r;
    int unsigned pick;
    longint      top;
    r.range_low  = $urandom;
    r.range_high = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 25) r.opcode = pcg_pkg::OP_RAW;
    else if (pick < 45) r.opcode = pcg_pkg::OP_FRAC;
    else if (pick < 92) r.opcode = pcg_pkg::OP_BOUNDED;
    else r.opcode = pcg_pkg::OP_RESEED;
    if (r.opcode == pcg_pkg::OP_BOUNDED) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          top = longint'(r.range_low) + $urandom_range(1, 40);
          if (top > longint'(MAX_INT)) top = longint'(MAX_INT);
          r.range_high = 32'(top);
        end
        4: ;  // fully random, inverted about half the time
        5: begin
          if (r.range_low <= r.range_high) r.range_low = r.range_high + 32'sd1;
          if (r.range_high == MAX_INT) r.range_low = MAX_INT;
          if (r.range_high == MAX_INT) r.range_high = $urandom_range(0, 100);
        end
        6: begin
          r.range_low  = MIN_INT;
          r.range_high = MAX_INT;
        end
        7: r.range_high = r.range_low;
        8: begin
          r.range_low  = {1'b1, r.range_low[30:0]};
          r.range_high = {1'b0, r.range_high[30:0]};
        end
        default: begin
          r.range_low  = MIN_INT + 32'($urandom_range(0, 3));
          r.range_high = MAX_INT - 32'($urandom_range(0, 3));
        end
      endcase
    end
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold on request
  initial begin
    rsp_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rsp_stall    <= 1'b0;
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    pcg_pkg::result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: bits %h integer %0d error %b",
               rsp.random_bits, rsp.random_integer, rsp.range_error);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (rsp.random_bits !== want.random_bits) begin
          $error("random_bits: expected %h, got %h", want.random_bits, rsp.random_bits);
          mismatch_count++;
        end
        if (rsp.random_integer !== want.random_integer) begin
          $error("random_integer: expected %0d, got %0d",
                 want.random_integer, rsp.random_integer);
          mismatch_count++;
        end
        if (rsp.range_error !== want.range_error) begin
          $error("range_error: expected %b, got %b", want.range_error, rsp.range_error);
          mismatch_count++;
        end
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(pcg_pkg::request_t r, logic typed, pcg_pkg::result_t answer);
    pcg_pkg::result_t model;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    model = compute_result(r);
    pending_results.push_back(typed ? answer : model);
    op_count[r.opcode]++;
    @(negedge clk);
  endtask

  // seed write, only once every result is back
  task automatic write_seed(logic [63:0] s);
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_seed  <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gen_seed = s;
    seeds_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // main sequence
  initial begin
    logic [63:0] phase_seed;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_seed  = '0;
    quiet     = 1'b0;
    hold_request    = 1'b0;
    mismatch_count  = 0;
    results_checked = 0;
    seeds_written   = 0;
    foreach (op_count[i]) op_count[i] = 0;
    gen_seed = '0;
    pcg_reseed(gen_seed);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    write_seed(64'hffff_ffff_ffff_ffff);
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_request(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].answer);
    end
    req_valid <= 1'b0;

    // random phases, each under its own seed
    for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
      case (phase)
        1:       phase_seed = 64'd0;
        2:       phase_seed = 64'd1;
        4:       phase_seed = 64'h8000_0000_0000_0000;
        default: phase_seed = {$urandom, $urandom};
      endcase
      write_seed(phase_seed);
      if (phase == 3) hold_request = 1'b1;
      if (phase == RANDOM_PHASES) quiet = 1'b1;
      repeat (RANDOM_PER_PHASE) send_request(random_request(), 1'b0, ZERO_RESULT);
      req_valid <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d raw, %0d fraction, %0d bounded and %0d reseed requests",
             op_count[pcg_pkg::OP_RAW], op_count[pcg_pkg::OP_FRAC],
             op_count[pcg_pkg::OP_BOUNDED], op_count[pcg_pkg::OP_RESEED]);
    $display("%0d seed writes, %0d results compared, %0d mismatches",
             seeds_written, results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
